### hw/rtl/snt_pkg.sv
// ----------------------------------------------------------------------------
// snt_pkg: shared types and constants
// Command codes, register indexes, the queued request, back-end states and
// saturation helpers for the sigmoid neuron.
// ----------------------------------------------------------------------------
package snt_pkg;

  localparam int CntW = 11;

  typedef enum logic [1:0] {
    CMD_FWD       = 2'd0,
    CMD_TRAIN_OUT = 2'd1,
    CMD_TRAIN_HID = 2'd2,
    CMD_LOAD      = 2'd3
  } cmd_t;

  localparam logic REG_RATE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam logic [15:0]     RATE_RESET  = 16'd6554;
  localparam logic [CntW-1:0] COUNT_RESET = 11'd1024;
  localparam logic [16:0]     ONE_Q16     = 17'd65536;
  localparam logic signed [47:0] HALF_RANGE = 48'sd524288;

  typedef struct packed {
    cmd_t                cmd;
    logic                last;
    logic [CntW-1:0]     addr;
    logic [CntW-1:0]     n;
    logic signed [31:0]  x;
    logic [16:0]         act;
    logic signed [31:0]  tgt;
  } op_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_LOAD, BK_FMUL, BK_FACC, BK_FBIAS, BK_FIDX,
    BK_TG, BK_TD, BK_TSAT, BK_TXD, BK_TRATE, BK_TWR, BK_TBMUL, BK_TBWR, BK_OUT
  } back_state_t;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'sd140737488355327) return 48'sh7FFF_FFFF_FFFF;
    if (v < -50'sd140737488355328) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -51'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

### hw/rtl/snt_if.sv
// ----------------------------------------------------------------------------
// snt_if: request and result channels
// Valid/ready channels carrying one neuron request or one result.
// ----------------------------------------------------------------------------
interface snt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] value;
  logic [10:0]        weight_index;
  logic [16:0]        activation;
  logic signed [31:0] target;
  modport source(output valid, cmd, value, weight_index, activation, target,
                 input ready);
  modport sink(input valid, cmd, value, weight_index, activation, target,
               output ready);
endinterface

interface snt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               result_kind;
  modport source(output valid, result_value, result_kind, input ready);
  modport sink(input valid, result_value, result_kind, output ready);
endinterface

### hw/rtl/sigmoid_neuron_train.sv
// ----------------------------------------------------------------------------
// sigmoid_neuron_train: trainable sigmoid neuron
// One neuron with stored Q16.16 weights and a bias, fed one element per request.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (valid/ready): forward, train as output, train as
// hidden, or load weight. Results leave on out_ch (valid/ready); only the last
// element of a vector yields one: the activation (kind 0) or delta (kind 1).
// learning_rate and input_count are written through wr_en/wr_index/wr_data
// by the user only while the block is idle; the block itself does not enforce it.
// An intake stage tracks the element position and feeds a two-entry queue;
// the execution sequencer works one request at a time over a weight memory
// with one read and one write port and a serial multiply chain. The result
// register lets the next request run while a result waits; the sequencer
// holds only when a second result is ready and the receiver still stalls.
// Reset clears the position, accumulator, queue and result register and
// restores the register defaults; weights are undefined until loaded.
// ----------------------------------------------------------------------------
module sigmoid_neuron_train #(
  parameter int MAX_INPUTS      = 1024,
  parameter int SIGMOID_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data,
  snt_in_if.sink      in_ch,
  snt_out_if.source   out_ch
);
  import snt_pkg::*;

  logic [15:0]     learning_rate;
  logic [CntW-1:0] input_count;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  op_t             q_in;
  op_t             q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= RATE_RESET;
      input_count   <= COUNT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_RATE:  learning_rate <= wr_data;
        REG_COUNT: input_count   <= wr_data[CntW-1:0];
        default: ;
      endcase
    end
  end

  snt_front #(.MAX_INPUTS(MAX_INPUTS)) u_front (
    .clk, .rst, .input_count, .in_ch, .q_full, .q_push, .q_data(q_in)
  );

  snt_fifo u_fifo (
    .clk, .rst, .push(q_push), .push_data(q_in), .pop(q_pop),
    .head(q_head), .full(q_full), .empty(q_empty)
  );

  snt_back #(.MAX_INPUTS(MAX_INPUTS), .SIGMOID_ENTRIES(SIGMOID_ENTRIES)) u_back (
    .clk, .rst, .learning_rate, .head(q_head), .q_empty, .q_pop, .out_ch
  );

endmodule

### hw/rtl/snt_front.sv
// ----------------------------------------------------------------------------
// snt_front: request intake
// Accepts requests, tracks the element position, drops out-of-range loads
// and hands classified requests to the queue.
// ----------------------------------------------------------------------------
module snt_front #(
  parameter int MAX_INPUTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [10:0]           input_count,
  snt_in_if.sink                in_ch,
  input  logic                  q_full,
  output logic                  q_push,
  output snt_pkg::op_t          q_data
);
  import snt_pkg::*;

  logic [CntW-1:0] pos;
  logic [CntW-1:0] n;
  logic [CntW-1:0] last_pos;
  logic [CntW-1:0] pos_eff;
  logic            is_last;
  logic            is_load;
  logic            accept;

  always_comb begin
    if (input_count == '0) begin
      n = CntW'(1);
    end else if (int'(input_count) > MAX_INPUTS) begin
      n = CntW'(MAX_INPUTS);
    end else begin
      n = input_count;
    end
  end

  assign last_pos = n - CntW'(1);
  assign pos_eff  = (pos > last_pos) ? last_pos : pos;
  assign is_last  = (pos_eff == last_pos);
  assign is_load  = (cmd_t'(in_ch.cmd) == CMD_LOAD);
  assign in_ch.ready = !q_full;
  assign accept   = in_ch.valid && in_ch.ready;
  // drop loads beyond the bias slot
  assign q_push   = accept && (!is_load || (in_ch.weight_index <= n));

  always_comb begin
    q_data.cmd  = cmd_t'(in_ch.cmd);
    q_data.last = is_last;
    q_data.addr = is_load ? in_ch.weight_index : pos_eff;
    q_data.n    = n;
    q_data.x    = in_ch.value;
    q_data.act  = (in_ch.activation > ONE_Q16) ? ONE_Q16 : in_ch.activation;
    q_data.tgt  = in_ch.target;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept && !is_load) begin
      pos <= is_last ? '0 : pos_eff + CntW'(1);
    end
  end

endmodule

### hw/rtl/snt_fifo.sv
// ----------------------------------------------------------------------------
// snt_fifo: request queue
// Two-entry queue between intake and execution.
// ----------------------------------------------------------------------------
module snt_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  snt_pkg::op_t  push_data,
  input  logic          pop,
  output snt_pkg::op_t  head,
  output logic          full,
  output logic          empty
);
  import snt_pkg::*;

  op_t        slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### hw/rtl/snt_back.sv
// ----------------------------------------------------------------------------
// snt_back: neuron execution
// Sequencer over the weight memory, the multiply chain, the accumulator,
// the sigmoid table and the result register.
// ----------------------------------------------------------------------------
module snt_back #(
  parameter int MAX_INPUTS      = 1024,
  parameter int SIGMOID_ENTRIES = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [15:0]   learning_rate,
  input  snt_pkg::op_t  head,
  input  logic          q_empty,
  output logic          q_pop,
  snt_out_if.source     out_ch
);
  import snt_pkg::*;

  localparam int AW = $clog2(MAX_INPUTS + 1);
  localparam int IW = $clog2(SIGMOID_ENTRIES);
  localparam int SW = 20 + IW + 1;

  typedef logic [16:0] rom_t [SIGMOID_ENTRIES];

  // shift-subtract quotient, used only while building the table
  function automatic longint unsigned cdiv(input longint unsigned num,
                                           input longint unsigned dvs);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= dvs) begin
        r    = r - dvs;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [16:0] sig_val(input int k);
    longint          mid;
    longint unsigned t, f, term, s, den, rpos;
    longint          acc;
    if (2 * k + 1 < 0) return 17'd0;
    mid  = -64'sd524288 + longint'(cdiv(longint'(2 * k + 1) <<< 19, SIGMOID_ENTRIES));
    t    = (mid < 0) ? longint'(-mid) : longint'(mid);
    f    = t << 13;
    acc  = 64'sd4294967296;
    term = 64'd4294967296;
    for (int i = 1; i <= 13; i++) begin
      term = cdiv((term * f) >> 32, longint'(i));
      if ((i & 1) == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    s = acc;
    for (int j = 0; j < 3; j++) begin
      if (s < 64'd4294967296) s = (s * s + 64'd2147483648) >> 32;
    end
    den  = 64'd4294967296 + s;
    rpos = cdiv((64'd1 << 48) + (den >> 1), den);
    if (mid < 0) return 17'(64'd65536 - rpos);
    return 17'(rpos);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) r[k] = sig_val(k);
    return r;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  back_state_t state, state_next;
  op_t op;

  logic signed [31:0] mem [MAX_INPUTS + 1];
  logic signed [31:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic signed [31:0] mem_wd;

  logic signed [47:0] acc;
  logic signed [63:0] prod;
  logic signed [47:0] bsum;
  logic [16:0]        rom_q;
  logic signed [31:0] wv;
  logic [14:0]        g;
  logic signed [48:0] dprod;
  logic signed [31:0] delta;
  logic signed [63:0] xd;
  logic signed [40:0] mhi;
  logic [39:0]        mlo;
  logic signed [48:0] bprod;
  logic signed [31:0] wb;
  logic               res_kind;
  logic               out_load;
  logic               out_valid;
  logic signed [31:0] out_value;
  logic               out_kind;

  logic [33:0]        gp;
  logic signed [32:0] diff;
  logic signed [49:0] acc_sum;
  logic signed [49:0] bias_sum;
  logic [19:0]        off;
  logic [SW-1:0]      scaled;
  logic [IW-1:0]      idx;
  logic signed [65:0] rate_full;
  logic signed [50:0] w_sum;
  logic signed [50:0] b_sum;

  assign gp       = 34'(op.act) * 34'(ONE_Q16 - op.act);
  assign diff     = (op.cmd == CMD_TRAIN_OUT) ? ({op.tgt[31], op.tgt} - $signed({16'd0, op.act}))
                                              : {op.tgt[31], op.tgt};
  assign acc_sum  = {{2{acc[47]}}, acc} + {{2{prod[63]}}, prod[63:16]};
  assign bias_sum = {{2{acc[47]}}, acc} + {{18{rd_data[31]}}, rd_data};
  assign off      = 20'(bsum + HALF_RANGE);
  assign scaled   = SW'(off) * SW'(SIGMOID_ENTRIES);

  always_comb begin
    if (bsum < -HALF_RANGE) begin
      idx = '0;
    end else if (bsum >= HALF_RANGE) begin
      idx = IW'(SIGMOID_ENTRIES - 1);
    end else begin
      idx = scaled[20 +: IW];
    end
  end

  assign rate_full = {{1{mhi[40]}}, mhi, 24'd0} + $signed({26'd0, mlo});
  assign w_sum     = {{19{wv[31]}}, wv} + {{1{rate_full[65]}}, rate_full[65:16]};
  assign b_sum     = {{19{wb[31]}}, wb} + {{18{bprod[48]}}, bprod[48:16]};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          case (head.cmd)
            CMD_LOAD: state_next = BK_LOAD;
            CMD_FWD:  state_next = BK_FMUL;
            default:  state_next = BK_TG;
          endcase
        end
      end
      BK_LOAD:  state_next = BK_IDLE;
      BK_FMUL:  state_next = BK_FACC;
      BK_FACC:  state_next = op.last ? BK_FBIAS : BK_IDLE;
      BK_FBIAS: state_next = BK_FIDX;
      BK_FIDX:  state_next = BK_OUT;
      BK_TG:    state_next = BK_TD;
      BK_TD:    state_next = BK_TSAT;
      BK_TSAT:  state_next = BK_TXD;
      BK_TXD:   state_next = BK_TRATE;
      BK_TRATE: state_next = BK_TWR;
      BK_TWR:   state_next = op.last ? BK_TBMUL : BK_IDLE;
      BK_TBMUL: state_next = BK_TBWR;
      BK_TBWR:  state_next = BK_OUT;
      BK_OUT:   state_next = (!out_valid || out_ch.ready) ? BK_IDLE : BK_OUT;
      default:  state_next = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = AW'(op.addr);
    mem_wd   = op.x;
    rd_addr  = AW'(op.addr);
    out_load = 1'b0;
    case (state)
      BK_IDLE: begin
        q_pop   = !q_empty;
        rd_addr = AW'(head.addr);
      end
      BK_LOAD: mem_we = 1'b1;
      BK_FACC: rd_addr = AW'(op.n);
      BK_TWR: begin
        mem_we  = 1'b1;
        mem_wd  = sat32(w_sum);
        rd_addr = AW'(op.n);
      end
      BK_TBWR: begin
        mem_we = 1'b1;
        mem_wa = AW'(op.n);
        mem_wd = sat32(b_sum);
      end
      BK_OUT: out_load = !out_valid || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      case (state)
        BK_FACC: acc <= sat48(acc_sum);
        BK_OUT:  if (out_load) acc <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) op <= head;
    case (state)
      BK_FMUL:  prod  <= op.x * rd_data;
      BK_FBIAS: bsum  <= sat48(bias_sum);
      BK_FIDX: begin
        rom_q    <= SIG_ROM[idx];
        res_kind <= 1'b0;
      end
      BK_TG: begin
        wv <= rd_data;
        g  <= gp[30:16];
      end
      BK_TD:    dprod <= $signed({1'b0, g}) * diff;
      BK_TSAT:  delta <= sat32({{18{dprod[48]}}, dprod[48:16]});
      BK_TXD:   xd    <= op.x * delta;
      BK_TRATE: begin
        mhi <= $signed(xd[63:40]) * $signed({1'b0, learning_rate});
        mlo <= 40'(xd[39:16]) * 40'(learning_rate);
      end
      BK_TBMUL: begin
        bprod    <= delta * $signed({1'b0, learning_rate});
        wb       <= rd_data;
        res_kind <= 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= res_kind ? delta : $signed({15'd0, rom_q});
      out_kind  <= res_kind;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.result_value = out_value;
  assign out_ch.result_kind  = out_kind;

endmodule
